// ===== hdl/cnw_pkg.sv =====
// Package for the character display nibble writer.
// Holds the display geometry, opcodes, job descriptor and nibble tables.
// Depends on nothing; every module of the block refers to it by scoped names.
package cnw_pkg;

  localparam int COLUMNS = 20;
  localparam int ROWS = 4;
  localparam int SCREEN = COLUMNS * ROWS;
  localparam int POS_W = 7;
  localparam int JOB_AW = 2;
  localparam int JOB_DEPTH = 1 << JOB_AW;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd12;

  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] LONG_MASK = 8'hfc;

  typedef enum logic [1:0] {
    OP_PUTC   = 2'd0,
    OP_SETCUR = 2'd1,
    OP_RAW    = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WAIT_PULSE = 2'd0,
    WAIT_SHORT = 2'd1,
    WAIT_LONG  = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    JOB_DATA = 2'd0,
    JOB_CMD  = 2'd1,
    JOB_INIT = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] first_byte;
    logic [7:0] addr_byte;
    logic       addr_en;
  } job_t;

  typedef struct packed {
    logic [3:0] nibble;
    wait_t      wait_class;
  } init_nib_t;

  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] off;
    case (r)
      2'd0: off = 8'h00;
      2'd1: off = 8'h40;
      2'd2: off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  function automatic logic [POS_W-1:0] row_base(input logic [1:0] r);
    return POS_W'(int'(r) * COLUMNS);
  endfunction

  function automatic init_nib_t init_nibble(input logic [STEP_W-1:0] step);
    init_nib_t n;
    case (step)
      4'd0: n = '{4'h3, WAIT_SHORT};
      4'd1: n = '{4'h2, WAIT_PULSE};
      4'd2: n = '{4'h8, WAIT_SHORT};
      4'd3: n = '{4'h2, WAIT_PULSE};
      4'd4: n = '{4'h8, WAIT_SHORT};
      4'd5: n = '{4'h0, WAIT_PULSE};
      4'd6: n = '{4'hc, WAIT_SHORT};
      4'd7: n = '{4'h0, WAIT_PULSE};
      4'd8: n = '{4'h1, WAIT_LONG};
      4'd9: n = '{4'h0, WAIT_PULSE};
      4'd10: n = '{4'h6, WAIT_SHORT};
      4'd11: n = '{4'h0, WAIT_PULSE};
      default: n = '{4'h1, WAIT_LONG};
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/cnw_front.sv =====
// Front end of the nibble writer: accepts items, keeps the cursor position
// and turns each item into one job descriptor. Depends on cnw_pkg.
module cnw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 job_full,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_byte_value,
  input  logic [1:0]           in_row,
  input  logic [4:0]           in_column,
  output logic                 job_push,
  output cnw_pkg::job_t        job
);

  logic [cnw_pkg::POS_W-1:0] cursor_r;
  logic [cnw_pkg::POS_W-1:0] cursor_nxt;
  logic [cnw_pkg::POS_W-1:0] pos_inc;
  logic [cnw_pkg::POS_W-1:0] pos_wrap;
  logic                      at_row_start;
  logic [1:0]                row_idx;
  logic [1:0]                row_cl;
  logic [4:0]                col_cl;

  assign job_push = push && !job_full;

  always_comb begin
    pos_inc = cursor_r + cnw_pkg::POS_W'(1);
    pos_wrap = (pos_inc >= cnw_pkg::POS_W'(cnw_pkg::SCREEN)) ? '0 : pos_inc;
    at_row_start = 1'b0;
    row_idx = '0;
    for (int i = 0; i < cnw_pkg::ROWS; i++) begin
      if (pos_wrap == cnw_pkg::row_base(2'(i))) begin
        at_row_start = 1'b1;
        row_idx = 2'(i);
      end
    end
    row_cl = (in_row > 2'(cnw_pkg::ROWS - 1)) ? 2'(cnw_pkg::ROWS - 1) : in_row;
    col_cl = (in_column > 5'(cnw_pkg::COLUMNS - 1)) ? 5'(cnw_pkg::COLUMNS - 1) : in_column;

    job = '{cnw_pkg::JOB_CMD, in_byte_value, '0, 1'b0};
    cursor_nxt = cursor_r;
    case (cnw_pkg::op_t'(in_opcode))
      cnw_pkg::OP_PUTC: begin
        job.kind = cnw_pkg::JOB_DATA;
        job.addr_en = at_row_start;
        job.addr_byte = cnw_pkg::SET_ADDR_CMD | cnw_pkg::row_offset(row_idx);
        cursor_nxt = pos_wrap;
      end
      cnw_pkg::OP_SETCUR: begin
        job.first_byte = cnw_pkg::SET_ADDR_CMD
                         | (cnw_pkg::row_offset(row_cl) + 8'(col_cl));
        cursor_nxt = cnw_pkg::row_base(row_cl) + cnw_pkg::POS_W'(col_cl);
      end
      cnw_pkg::OP_RAW: begin
        job.kind = cnw_pkg::JOB_CMD;
      end
      default: begin
        job.kind = cnw_pkg::JOB_INIT;
        cursor_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (job_push) begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

// ===== hdl/cnw_job_fifo.sv =====
// Short job queue between the front and back ends of the nibble writer.
// Depends on cnw_pkg for the job descriptor and the queue depth.
module cnw_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cnw_pkg::job_t wr_job,
  input  logic          rd_en,
  output logic          full,
  output logic          rd_valid,
  output cnw_pkg::job_t rd_job
);

  cnw_pkg::job_t                 mem_r [cnw_pkg::JOB_DEPTH];
  logic [cnw_pkg::JOB_AW-1:0]    wr_ptr_r;
  logic [cnw_pkg::JOB_AW-1:0]    rd_ptr_r;
  logic [cnw_pkg::JOB_AW:0]      count_r;
  logic [cnw_pkg::JOB_AW:0]      count_nxt;

  assign full = (count_r == (cnw_pkg::JOB_AW + 1)'(cnw_pkg::JOB_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !(rd_en && rd_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en && rd_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cnw_back.sv =====
// Back end of the nibble writer: expands the job at the head of the queue
// into nibble transfers and holds one in the output register. Depends on cnw_pkg.
module cnw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  cnw_pkg::job_t job,
  output logic          job_pop,
  input  logic          pop,
  output logic          empty,
  output logic          out_register_select,
  output logic [3:0]    out_nibble,
  output logic [1:0]    out_wait_class,
  output logic          out_last
);

  logic [cnw_pkg::STEP_W-1:0] step_r;
  logic [cnw_pkg::STEP_W-1:0] step_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       rs_r;
  logic [3:0]                 nibble_r;
  cnw_pkg::wait_t             wait_r;
  logic                       last_r;
  logic                       advance;
  logic                       rs;
  logic [3:0]                 nibble;
  cnw_pkg::wait_t             wait_cls;
  logic                       last;
  cnw_pkg::init_nib_t         init_nib;

  assign advance = job_valid && (!out_valid_r || pop);
  assign job_pop = advance && last;

  always_comb begin
    rs = 1'b0;
    nibble = job.first_byte[7:4];
    wait_cls = cnw_pkg::WAIT_PULSE;
    last = 1'b0;
    init_nib = cnw_pkg::init_nibble(step_r);
    case (job.kind)
      cnw_pkg::JOB_DATA: begin
        case (step_r[1:0])
          2'd0: begin
            rs = 1'b1;
          end
          2'd1: begin
            rs = 1'b1;
            nibble = job.first_byte[3:0];
            wait_cls = cnw_pkg::WAIT_SHORT;
            last = !job.addr_en;
          end
          2'd2: begin
            nibble = job.addr_byte[7:4];
          end
          default: begin
            nibble = job.addr_byte[3:0];
            wait_cls = cnw_pkg::WAIT_SHORT;
            last = 1'b1;
          end
        endcase
      end
      cnw_pkg::JOB_CMD: begin
        if (step_r[0]) begin
          nibble = job.first_byte[3:0];
          wait_cls = ((job.first_byte & cnw_pkg::LONG_MASK) == '0)
                     ? cnw_pkg::WAIT_LONG : cnw_pkg::WAIT_SHORT;
          last = 1'b1;
        end
      end
      default: begin
        nibble = init_nib.nibble;
        wait_cls = init_nib.wait_class;
        last = (step_r == cnw_pkg::INIT_LAST_STEP);
      end
    endcase

    step_nxt = step_r;
    if (advance) begin
      step_nxt = last ? '0 : step_r + 1'b1;
    end
    out_valid_nxt = advance || (out_valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rs_r <= rs;
      nibble_r <= nibble;
      wait_r <= wait_cls;
      last_r <= last;
    end
  end

  assign empty = !out_valid_r;
  assign out_register_select = rs_r;
  assign out_nibble = nibble_r;
  assign out_wait_class = wait_r;
  assign out_last = last_r;

endmodule

// ===== hdl/char_lcd_nibble_writer_top.sv =====
// Character display writer for a 4-bit HD44780-style bus.
// Both sides behave as queues. An item (opcode, byte, row, column) is taken
// at a clock edge where push is high and full is low. Results wait on the out_
// ports while empty is low and leave at an edge where pop is high.
// Each result is one nibble transfer with register select, a wait class and
// a last flag on the final nibble of its item.
// A put-character item gives two nibbles, or four when the cursor reaches the
// start of a row; set cursor and raw command give two; init gives thirteen.
// When the queues are empty, an accepted item is written into the job queue and
// its first nibble is then loaded into the output register. The back end
// emits one nibble per cycle while pop is high or the output is empty.
// A four-entry job queue lets the front keep accepting items while the back
// end works; full rises only when that queue holds four pending jobs.
// When pop stays low, the output register holds its nibble and the back end
// and then the queue stall; no transfer is lost.
// Reset clears the cursor to the top left position and empties both queues.
// Depends on cnw_pkg, cnw_front, cnw_job_fifo and cnw_back.
module char_lcd_nibble_writer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_byte_value,
  input  logic [1:0] in_row,
  input  logic [4:0] in_column,
  output logic       empty,
  input  logic       pop,
  output logic       out_register_select,
  output logic [3:0] out_nibble,
  output logic [1:0] out_wait_class,
  output logic       out_last
);

  logic          job_push;
  logic          job_full;
  logic          job_valid;
  logic          job_pop;
  cnw_pkg::job_t front_job;
  cnw_pkg::job_t head_job;

  assign full = job_full;

  cnw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .job_full     (job_full),
    .in_opcode    (in_opcode),
    .in_byte_value(in_byte_value),
    .in_row       (in_row),
    .in_column    (in_column),
    .job_push     (job_push),
    .job          (front_job)
  );

  cnw_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (front_job),
    .rd_en   (job_pop),
    .full    (job_full),
    .rd_valid(job_valid),
    .rd_job  (head_job)
  );

  cnw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (job_valid),
    .job                (head_job),
    .job_pop            (job_pop),
    .pop                (pop),
    .empty              (empty),
    .out_register_select(out_register_select),
    .out_nibble         (out_nibble),
    .out_wait_class     (out_wait_class),
    .out_last           (out_last)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("Job queue popped while empty.");

  a_full_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_full |-> job_valid)
    else $error("Job queue reports full without a head job.");

  a_last_not_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_wait_class != cnw_pkg::WAIT_PULSE))
    else $error("Final nibble of an item carries only an enable pulse.");

  a_long_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_wait_class == cnw_pkg::WAIT_LONG) |-> !out_register_select)
    else $error("Long wait on a data register transfer.");
`endif

endmodule
